// ===== hdl/sbs_pkg.sv =====
// Shared types and constants for the spectrum boxcar smoother.
package sbs_pkg;

  localparam int DATA_W    = 32;
  localparam int BIN_W     = 14;
  localparam int WIN_W     = 7;
  localparam int SUM_W     = DATA_W + WIN_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic capture;
    logic check;
    logic setup;
    logic step;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic tail;
    logic last_term;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/sbs_ctrl.sv =====
// Controller state machine of the spectrum boxcar smoother.
module sbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sbs_pkg::dp_status_t  status,
  output sbs_pkg::ctl_cmd_t    cmd
);
  import sbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_SUM     = 7'b0000100,
    S_DRAIN   = 7'b0001000,
    S_DIVINIT = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_LOAD:  cmd.load = 1'b1;
            CMD_CLEAR: cmd.clear = 1'b1;
            CMD_READ: begin
              cmd.capture = 1'b1;
              state_nxt   = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.err || status.tail) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.step = 1'b1;
        if (status.last_term) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result only appears after the finish state.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish state");

  // Once the divider reports done, the controller moves to the finish state next.
  a_div_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_done) |=> (state_r == S_FINISH))
    else $error("divider done did not lead to finish");

  // A blocked result keeps the controller waiting with the result held.
  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready)
      |=> (state_r == S_FINISH && out_valid_r))
    else $error("pending result lost while finishing");

endmodule

// ===== hdl/sbs_datapath.sv =====
// Datapath of the spectrum boxcar smoother: store, accumulator and divider.
module sbs_datapath #(
  parameter int MAX_POINTS = 16384,
  parameter int MAX_WINDOW = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbs_pkg::ctl_cmd_t                 cmd,
  output sbs_pkg::dp_status_t               status,
  input  logic                              cfg_we,
  input  logic [sbs_pkg::WIN_W-1:0]         cfg_window,
  input  logic signed [sbs_pkg::DATA_W-1:0] in_real,
  input  logic signed [sbs_pkg::DATA_W-1:0] in_imag,
  input  logic [sbs_pkg::BIN_W-1:0]         in_bin,
  output logic signed [sbs_pkg::DATA_W-1:0] out_real,
  output logic signed [sbs_pkg::DATA_W-1:0] out_imag,
  output logic                              out_err
);
  import sbs_pkg::*;

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int KW     = ((CNT_W > BIN_W) ? CNT_W : BIN_W) + 2;
  localparam int WMAX   = (1 << WIN_W) - 1;
  localparam int WCAP   = (MAX_WINDOW < WMAX) ? MAX_WINDOW : WMAX;
  localparam logic [WIN_W-1:0] WCAP_V = WIN_W'(WCAP);
  localparam logic [CNT_W-1:0] FULL   = CNT_W'(MAX_POINTS);

  logic [2*DATA_W-1:0] store_mem [MAX_POINTS];

  logic [WIN_W-1:0]        win_r;
  logic [CNT_W-1:0]        count_r;
  logic [BIN_W-1:0]        idx_r;
  logic [KW-1:0]           k_r;
  logic [WIN_W-1:0]        left_r;
  logic [2*DATA_W-1:0]     rd_data_r;
  logic                    acc_v_r;
  logic                    acc_m_r;
  logic signed [SUM_W-1:0] sum_re_r;
  logic signed [SUM_W-1:0] sum_im_r;
  logic [SUM_W-1:0]        quo_re_r;
  logic [SUM_W-1:0]        quo_im_r;
  logic [WIN_W-1:0]        rem_re_r;
  logic [WIN_W-1:0]        rem_im_r;
  logic                    neg_re_r;
  logic                    neg_im_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;
  logic                    err_r;
  logic                    zero_r;
  logic [DATA_W-1:0]       out_real_r;
  logic [DATA_W-1:0]       out_imag_r;
  logic                    out_err_r;

  logic [WIN_W-1:0]          weff;
  logic [WIN_W-1:0]          half;
  logic [KW-1:0]             idx_k;
  logic [KW-1:0]             cnt_k;
  logic [KW-1:0]             half_k;
  logic                      low_bin;
  logic [KW-1:0]             start_k;
  logic                      full;
  logic [WIN_W+SUM_W-1:0]    step_re;
  logic [WIN_W+SUM_W-1:0]    step_im;
  logic [DATA_W-1:0]         q_re;
  logic [DATA_W-1:0]         q_im;

  // One restoring division step: shift one dividend bit into the remainder.
  function automatic logic [WIN_W+SUM_W-1:0] div_step_f(
    input logic [WIN_W-1:0] rem,
    input logic [SUM_W-1:0] quo,
    input logic [WIN_W-1:0] dvs
  );
    logic [WIN_W:0] sh;
    logic [WIN_W:0] diff;
    sh   = {rem, quo[SUM_W-1]};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      return {diff[WIN_W-1:0], quo[SUM_W-2:0], 1'b1};
    end
    return {sh[WIN_W-1:0], quo[SUM_W-2:0], 1'b0};
  endfunction

  always_comb begin
    if (win_r == '0) begin
      weff = WIN_W'(1);
    end else if (win_r > WCAP_V) begin
      weff = WCAP_V;
    end else begin
      weff = win_r;
    end
  end

  assign half    = weff >> 1;
  assign idx_k   = KW'(idx_r);
  assign cnt_k   = KW'(count_r);
  assign half_k  = KW'(half);
  assign low_bin = idx_k < half_k;
  assign start_k = low_bin ? idx_k : (idx_k - half_k);
  assign full    = (count_r == FULL);

  assign status.err       = (idx_k >= cnt_k);
  assign status.tail      = !low_bin && !((idx_k + half_k) < cnt_k);
  assign status.last_term = (left_r == WIN_W'(1));
  assign status.div_done  = (div_cnt_r == '0);

  assign step_re = div_step_f(rem_re_r, quo_re_r, weff);
  assign step_im = div_step_f(rem_im_r, quo_im_r, weff);
  assign q_re    = neg_re_r ? (~quo_re_r[DATA_W-1:0] + DATA_W'(1)) : quo_re_r[DATA_W-1:0];
  assign q_im    = neg_im_r ? (~quo_im_r[DATA_W-1:0] + DATA_W'(1)) : quo_im_r[DATA_W-1:0];

  // Store: one write port for loads, one registered read port for sums.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store_mem[count_r[AW-1:0]] <= {in_real, in_imag};
    end
    if (cmd.step) begin
      rd_data_r <= store_mem[k_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WIN_W'(1);
      count_r   <= '0;
      acc_v_r   <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_window;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.load && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
      acc_v_r <= cmd.step;
      if (cmd.div_init) begin
        div_cnt_r <= DIV_CNT_W'(SUM_W);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_bin;
    end
    if (cmd.check) begin
      err_r  <= status.err;
      zero_r <= status.err || status.tail;
    end
    if (cmd.setup) begin
      k_r    <= start_k;
      left_r <= weff;
    end else if (cmd.step) begin
      k_r    <= k_r + KW'(1);
      left_r <= left_r - WIN_W'(1);
    end
    acc_m_r <= (k_r < cnt_k);
    // Bins past the stored count add nothing.
    if (cmd.setup) begin
      sum_re_r <= '0;
      sum_im_r <= '0;
    end else if (acc_v_r && acc_m_r) begin
      sum_re_r <= sum_re_r + SUM_W'($signed(rd_data_r[2*DATA_W-1:DATA_W]));
      sum_im_r <= sum_im_r + SUM_W'($signed(rd_data_r[DATA_W-1:0]));
    end
    if (cmd.div_init) begin
      neg_re_r <= sum_re_r[SUM_W-1];
      neg_im_r <= sum_im_r[SUM_W-1];
      quo_re_r <= sum_re_r[SUM_W-1] ? SUM_W'(-sum_re_r) : SUM_W'(sum_re_r);
      quo_im_r <= sum_im_r[SUM_W-1] ? SUM_W'(-sum_im_r) : SUM_W'(sum_im_r);
      rem_re_r <= '0;
      rem_im_r <= '0;
    end else if (cmd.div_step) begin
      {rem_re_r, quo_re_r} <= step_re;
      {rem_im_r, quo_im_r} <= step_im;
    end
    if (cmd.out_load) begin
      out_real_r <= zero_r ? '0 : q_re;
      out_imag_r <= zero_r ? '0 : q_im;
      out_err_r  <= err_r;
    end
  end

  assign out_real = out_real_r;
  assign out_imag = out_imag_r;
  assign out_err  = out_err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("stored count beyond store depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && err_r) |=> (out_real_r == '0 && out_imag_r == '0 && out_err_r))
    else $error("out-of-range request produced nonzero data");

endmodule

// ===== hdl/spectrum_boxcar_smoother_unit.sv =====
// Top level of the spectrum boxcar smoother: controller plus datapath.
//
//  channel   direction  handshake               payload
//  in_       input      in_valid / in_ready     command, real_part, imag_part, bin_index
//  out_      output     out_valid / out_ready   smoothed_real, smoothed_imag, index_error
//  cfg_      input      cfg_valid / cfg_ready   window_length
//
// A load, clear or unused request leaves the controller idle; the next request can follow at once.
// A read that is out of range or lands in the tail goes from the check state to the finish state.
// Any other read passes the check, sum, drain, divider-init, divide and finish states: the store is
// read one bin per cycle, and then a restoring divider produces one quotient bit per cycle.
// Reset clears the stored count and sets the window to one; the store itself is not cleared.
// A stalled result waits in the output register while later loads and clears proceed.
module spectrum_boxcar_smoother_unit #(
  parameter int MAX_POINTS = 16384,
  parameter int MAX_WINDOW = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic signed [sbs_pkg::DATA_W-1:0] in_real_part,
  input  logic signed [sbs_pkg::DATA_W-1:0] in_imag_part,
  input  logic [sbs_pkg::BIN_W-1:0]         in_bin_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sbs_pkg::DATA_W-1:0] out_smoothed_real,
  output logic signed [sbs_pkg::DATA_W-1:0] out_smoothed_imag,
  output logic                              out_index_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbs_pkg::WIN_W-1:0]         cfg_window_length
);
  import sbs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // The window register takes a write in any cycle; the user must write it only while idle (not enforced).
  assign cfg_ready = 1'b1;

  // The controller sequences each request; it never touches the data itself.
  sbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the store, the window sum and the divider, and the result register.
  sbs_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_window (cfg_window_length),
    .in_real    (in_real_part),
    .in_imag    (in_imag_part),
    .in_bin     (in_bin_index),
    .out_real   (out_smoothed_real),
    .out_imag   (out_smoothed_imag),
    .out_err    (out_index_error)
  );

endmodule
